/* rtl/lkv_pkg.sv */
`default_nettype none

package lkv_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Widest slot index the block supports (up to 256 entries)
  localparam int unsigned SLOT_W_MAX = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] READ_MISS = 32'hFFFF_FFFF;

  // Command to the recency rank file
  typedef struct packed {
    logic                  en;      // promote slot to most recent
    logic                  insert;  // new entry: age every other valid entry, set valid
    logic [SLOT_W_MAX-1:0] slot;
  } lkv_rank_cmd_t;

endpackage

`default_nettype wire

/* rtl/lkv_req_if.sv */
`default_nettype none

interface lkv_req_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

`default_nettype wire

/* rtl/lkv_rsp_if.sv */
`default_nettype none

interface lkv_rsp_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic             evicted;

  modport source (output valid, found, read_value, evicted, input ready);
  modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

`default_nettype wire

/* rtl/lkv_rank_file.sv */
`default_nettype none

module lkv_rank_file import lkv_pkg::*; #(
  parameter int unsigned MaxEntries = 16,
  parameter int unsigned IdxW       = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lkv_rank_cmd_t   cmd_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output logic                 rd_valid_o,
  output logic [IdxW-1:0]      rd_rank_o
);

  logic [MaxEntries-1:0] valid_q, valid_d;
  logic [IdxW-1:0]       rank_q [MaxEntries];
  logic [IdxW-1:0]       rank_d [MaxEntries];
  logic [IdxW-1:0]       slot;
  logic [IdxW-1:0]       limit;

  assign slot       = cmd_i.slot[IdxW-1:0];
  assign limit      = rank_q[slot];
  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];

  // Age every valid entry more recent than slot (on insert, every other valid entry), then put slot on top
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < MaxEntries; i++) begin
      rank_d[i] = rank_q[i];
      if (cmd_i.en && (IdxW'(i) != slot) && valid_q[i] &&
          (cmd_i.insert || (rank_q[i] < limit))) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
    if (cmd_i.en) begin
      rank_d[slot] = '0;
      if (cmd_i.insert) begin
        valid_d[slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lru_key_value_cache_top.sv */
// Fully associative key/value cache with least-recently-used replacement.
//
// Channels: req carries one item (func, key, value); func 0 is a get, func 1
// a put. rsp returns one item per request (found, read_value, evicted). A get
// miss reads back all ones; a put always reads back zero.
// Configuration: cfg_we_i writes cfg_wdata_i into the capacity register.
// Capacity zero behaves as one; capacity above MAX_ENTRIES behaves as
// MAX_ENTRIES. Write it only while no request is in flight.
//
// Timing: one key comparator walks the key memory one entry per cycle; a
// request passes the scan state, a decide state and a response state, and
// the result then sits in the output register. No new request is taken
// before the previous one leaves the response state: req.ready is high
// only while the sequencer idles.
//
// Reset empties the cache (all entries invalid, ranks zero, occupancy zero)
// and sets capacity to 16. If the receiver stalls, the result waits in the
// output register; the next request may still be accepted and scanned, and
// it holds in its response cycle until the output register frees up.
`default_nettype none

module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  lkv_req_if.sink               req,
  lkv_rsp_if.source             rsp
);

  localparam int unsigned IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > CAP_W) ? CntW : CAP_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic [CntW-1:0]  occ_q, occ_d;

  // Request hold
  logic             func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  // Scan sequencer
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic [IdxW-1:0]  pidx_q, pidx_d;

  // Scan findings
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             lru_q, lru_d;
  logic [IdxW-1:0]  lru_idx_q, lru_idx_d;
  logic [IdxW-1:0]  lru_rank_q, lru_rank_d;
  logic             free_q, free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;

  // Result hold
  logic             res_found_q, res_found_d;
  logic [VAL_W-1:0] res_read_q, res_read_d;
  logic             res_evict_q, res_evict_d;
  logic             res_mem_q, res_mem_d;

  // Output register
  logic             out_valid_q;
  logic             out_found_q;
  logic [VAL_W-1:0] out_read_q;
  logic             out_evict_q;
  logic             out_load;

  // Memories
  logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
  logic             key_re, key_we, val_re, val_we;
  logic [IdxW-1:0]  key_raddr, key_waddr, val_raddr, val_waddr;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;

  // Rank file
  lkv_rank_cmd_t    rank_cmd;
  logic             rd_valid;
  logic [IdxW-1:0]  rd_rank;

  logic             req_acc;
  logic             cache_full;
  logic             do_evict;
  logic [IdxW-1:0]  ins_slot;

  assign req.ready = (state_q == ST_IDLE);
  assign req_acc   = req.valid && req.ready;

  assign rsp.valid      = out_valid_q;
  assign rsp.found      = out_found_q;
  assign rsp.read_value = out_read_q;
  assign rsp.evicted    = out_evict_q;

  // occupancy >= min(capacity, MAX_ENTRIES); capacity zero always counts as full
  assign cache_full = ((cap_q == '0) && (occ_q != '0)) ||
                      (CmpW'(occ_q) >= CmpW'(cap_q)) ||
                      (occ_q == CntW'(MAX_ENTRIES));
  assign do_evict   = cache_full && lru_q;
  assign ins_slot   = do_evict ? lru_idx_q : free_idx_q;

  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

  lkv_rank_file #(
    .MaxEntries (MAX_ENTRIES),
    .IdxW       (IdxW)
  ) u_rank_file (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rank_cmd),
    .rd_idx_i   (pidx_q),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    lru_d       = lru_q;
    lru_idx_d   = lru_idx_q;
    lru_rank_d  = lru_rank_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    res_found_d = res_found_q;
    res_read_d  = res_read_q;
    res_evict_d = res_evict_q;
    res_mem_d   = res_mem_q;
    key_re      = 1'b0;
    key_raddr   = cnt_q[IdxW-1:0];
    key_we      = 1'b0;
    key_waddr   = ins_slot;
    val_re      = 1'b0;
    val_raddr   = hit_idx_q;
    val_we      = 1'b0;
    val_waddr   = hit_idx_q;
    rank_cmd    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          lru_d   = 1'b0;
          free_d  = 1'b0;
        end
      end

      ST_SCAN: begin
        // Issue the next key read
        if (cnt_q != CntW'(MAX_ENTRIES)) begin
          key_re = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = cnt_q[IdxW-1:0];
        end
        // Compare the entry read last cycle
        if (pv_q) begin
          if (rd_valid && !hit_q && (key_rd_q == key_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx_q;
          end
          if (rd_valid && (!lru_q || (rd_rank > lru_rank_q))) begin
            lru_d      = 1'b1;
            lru_idx_d  = pidx_q;
            lru_rank_d = rd_rank;
          end
          if (!rd_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = pidx_q;
          end
          if (pidx_q == IdxW'(MAX_ENTRIES - 1)) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_d     = ST_RESP;
        res_found_d = hit_q;
        res_evict_d = 1'b0;
        res_mem_d   = 1'b0;
        res_read_d  = '0;
        if (hit_q) begin
          rank_cmd.en   = 1'b1;
          rank_cmd.slot = SLOT_W_MAX'(hit_idx_q);
          if (!func_q) begin
            val_re    = 1'b1;
            res_mem_d = 1'b1;
          end else begin
            val_we = 1'b1;
          end
        end else if (!func_q) begin
          res_read_d = READ_MISS;
        end else if (do_evict || free_q) begin
          res_evict_d     = do_evict;
          rank_cmd.en     = 1'b1;
          rank_cmd.insert = 1'b1;
          rank_cmd.slot   = SLOT_W_MAX'(ins_slot);
          key_we          = 1'b1;
          val_we          = 1'b1;
          val_waddr       = ins_slot;
          if (!do_evict) begin
            occ_d = occ_q + 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      hit_q       <= 1'b0;
      lru_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      hit_q   <= hit_d;
      lru_q   <= lru_d;
      free_q  <= free_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // Hold the result until taken; drop valid once the sink takes it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      func_q  <= req.func;
      key_q   <= req.key;
      value_q <= req.value;
    end
    pidx_q      <= pidx_d;
    hit_idx_q   <= hit_idx_d;
    lru_idx_q   <= lru_idx_d;
    lru_rank_q  <= lru_rank_d;
    free_idx_q  <= free_idx_d;
    res_found_q <= res_found_d;
    res_read_q  <= res_read_d;
    res_evict_q <= res_evict_d;
    res_mem_q   <= res_mem_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_read_q  <= res_mem_q ? val_rd_q : res_read_q;
      out_evict_q <= res_evict_q;
    end
  end

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_q;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= value_q;
    end
    if (val_re) begin
      val_rd_q <= val_mem[val_raddr];
    end
  end

endmodule

`default_nettype wire
